// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file bsc_checker.sv.
// Needs clk and rst in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, suspended while rst is high.
`define BSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BSC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/bsc_pkg.sv -----
// Shared types, constants and helpers for the barometric compensation block.
// No dependencies.
`default_nettype none

package bsc_pkg;

  localparam logic [32:0]        FINE_OFFSET = 33'd128000;
  localparam logic [20:0]        PRESS_FULL  = 21'd1048576;
  localparam logic signed [16:0] PRESS_SCALE = 17'sd3125;
  localparam int unsigned        DIV_STEPS   = 64;
  localparam int unsigned        ADDR_W      = 5;

  typedef enum logic [1:0] {
    REG_TEMP_CAL   = 2'd0,
    REG_PRESS_LOW  = 2'd1,
    REG_PRESS_HIGH = 2'd2,
    REG_PRESS_LAST = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } cal_t;

  typedef struct packed {
    logic [31:0] temperature_centi;
    logic [31:0] fine_temperature;
    logic [19:0] raw_pressure;
  } queue_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic [31:0] temperature_centi;
    logic [31:0] fine_temperature;
    logic        no_divisor;
  } back_tag_t;

  // Low 64 bits of a * b, b signed 17 bits; a 50-bit low partial product and a 32-bit high one.
  function automatic logic [63:0] mul64x17(input logic [63:0] a, input logic signed [16:0] b);
    logic signed [49:0] lo;
    logic [31:0]        hi;
    lo = $signed({1'b0, a[31:0]}) * b;
    hi = a[63:32] * {{15{b[16]}}, b};
    return {{14{lo[49]}}, lo} + {hi, 32'd0};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bsc_front.sv -----
// Front end: takes requests, computes temperature and fine temperature.
// Depends on bsc_pkg; feeds bsc_queue.
`default_nettype none

module bsc_front import bsc_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cal_t          cal,
  input  wire logic          raw_valid,
  output logic               raw_stall,
  input  wire logic [19:0]   raw_temperature,
  input  wire logic [19:0]   raw_pressure,
  input  wire queue_status_t q_status,
  output logic               push,
  output queue_item_t        push_item
);

  logic               adv;
  logic               f1_valid, f2_valid, f3_valid;
  logic signed [17:0] f1_a;
  logic signed [16:0] f1_b;
  logic [19:0]        f1_rawp, f2_rawp, f3_rawp;
  logic signed [31:0] f2_tv1;
  logic signed [19:0] f2_s;
  logic signed [31:0] f3_fine;

  logic signed [17:0] a_c;
  logic signed [16:0] b_c;
  logic signed [33:0] m1_c, bb_c;
  logic signed [35:0] m3_c;
  logic signed [31:0] tv1_c, tv2_c, fine_c, f5_c, temp_c;

  assign adv       = !f3_valid || !q_status.full;
  assign raw_stall = !adv;

  always_comb begin
    a_c    = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
    b_c    = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, cal.t1});
    m1_c   = f1_a * $signed(cal.t2);
    bb_c   = f1_b * f1_b;
    tv1_c  = $signed(m1_c[31:0]) >>> 11;
    m3_c   = f2_s * $signed(cal.t3);
    tv2_c  = $signed(m3_c[31:0]) >>> 14;
    fine_c = f2_tv1 + tv2_c;
    f5_c   = (f3_fine <<< 2) + f3_fine + 32'sd128;
    temp_c = f5_c >>> 8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
    end else if (adv) begin
      f1_valid <= raw_valid;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_a    <= a_c;
      f1_b    <= b_c;
      f1_rawp <= raw_pressure;
      f2_tv1  <= tv1_c;
      f2_s    <= $signed(bb_c[31:12]);
      f2_rawp <= f1_rawp;
      f3_fine <= fine_c;
      f3_rawp <= f2_rawp;
    end
  end

  assign push                        = f3_valid && !q_status.full;
  assign push_item.temperature_centi = temp_c;
  assign push_item.fine_temperature  = f3_fine;
  assign push_item.raw_pressure      = f3_rawp;

endmodule

`default_nettype wire

// ----- rtl/core/bsc_queue.sv -----
// Small register FIFO between the front and back ends.
// Depends on bsc_pkg.
`default_nettype none

module bsc_queue import bsc_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire queue_item_t push_item,
  input  wire logic        pop,
  output queue_item_t      head,
  output queue_status_t    status
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  queue_item_t   slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign head         = slots[rd_ptr];
  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bsc_div.sv -----
// Pipelined unsigned divider, one quotient bit per stage, 64 / 31 bits.
// Depends on bsc_pkg; used by bsc_back.
`default_nettype none

module bsc_div import bsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire back_tag_t   in_tag,
  input  wire logic        in_neg,
  input  wire logic [63:0] dividend,
  input  wire logic [30:0] divisor,
  output logic             out_valid,
  output back_tag_t        out_tag,
  output logic             out_neg,
  output logic [63:0]      quotient
);

  logic        st_valid [DIV_STEPS];
  back_tag_t   st_tag   [DIV_STEPS];
  logic        st_neg   [DIV_STEPS];
  logic [30:0] st_rem   [DIV_STEPS];
  logic [30:0] st_dsr   [DIV_STEPS];
  logic [63:0] st_dvd   [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic        src_valid;
    back_tag_t   src_tag;
    logic        src_neg;
    logic [30:0] src_rem, src_dsr;
    logic [63:0] src_dvd;
    logic [31:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign src_valid = in_valid;
      assign src_tag   = in_tag;
      assign src_neg   = in_neg;
      assign src_rem   = '0;
      assign src_dsr   = divisor;
      assign src_dvd   = dividend;
    end else begin : g_next
      assign src_valid = st_valid[k-1];
      assign src_tag   = st_tag[k-1];
      assign src_neg   = st_neg[k-1];
      assign src_rem   = st_rem[k-1];
      assign src_dsr   = st_dsr[k-1];
      assign src_dvd   = st_dvd[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign trial = {src_rem, src_dvd[63]};
    assign ge    = (trial >= {1'b0, src_dsr});

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k] <= 1'b0;
      end else if (en) begin
        st_valid[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_tag[k] <= src_tag;
        st_neg[k] <= src_neg;
        st_dsr[k] <= src_dsr;
        st_rem[k] <= ge ? 31'(trial - {1'b0, src_dsr}) : trial[30:0];
        st_dvd[k] <= {src_dvd[62:0], ge};
      end
    end
  end

  assign out_valid = st_valid[DIV_STEPS-1];
  assign out_tag   = st_tag[DIV_STEPS-1];
  assign out_neg   = st_neg[DIV_STEPS-1];
  assign quotient  = st_dvd[DIV_STEPS-1];

endmodule

`default_nettype wire

// ----- rtl/core/bsc_back.sv -----
// Back end: 64-bit pressure pipeline with divider and output register.
// Depends on bsc_pkg and bsc_div; fed from bsc_queue.
`default_nettype none

module bsc_back import bsc_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cal_t          cal,
  input  wire queue_status_t q_status,
  input  wire queue_item_t   head,
  output logic               pop,
  output logic               result_valid,
  input  wire logic          result_stall,
  output logic [31:0]        temperature_centi,
  output logic [31:0]        fine_temperature,
  output logic [31:0]        pressure_q24_8,
  output logic               pressure_valid
);

  logic       adv;
  logic [7:0] pre_valid;
  logic [6:0] post_valid;

  // pre-divide stages
  back_tag_t          tag0, tag1, tag2, tag3, tag4, tag5, tag6, tag7;
  logic signed [32:0] x0, x1;
  logic [20:0]        pw0, pw1, pw2, pw3;
  logic [63:0]        sq1, sq2;
  logic signed [48:0] xp5_1, xp5_2, xp2_2, xp2_3;
  logic [63:0]        sqp6_2, sqp3_3, v2_3, v1a_4, num_pre_4, v1b_5, num_pre_5, num_6;
  logic signed [30:0] d_6;
  logic [63:0]        ua_7;
  logic [30:0]        ub_7;
  logic               neg_7;

  // divider outputs
  logic        dv_valid, dv_neg;
  back_tag_t   dv_tag;
  logic [63:0] dv_q;

  // post-divide stages
  back_tag_t   tage, tagp1, tagp2, tagp3, tagp4, tagp5;
  logic [63:0] pe, pp1, pp2, pp3, pp4;
  logic [63:0] t13_1, p8p_1, p8p_2, p8p_3, p8p_4, lo2_2, sq13_3, m9_4, sum_5;
  logic [31:0] hl_2;

  logic signed [32:0] x_c;
  logic [20:0]        pw_c;
  logic signed [65:0] sq_c;
  logic [63:0]        t13_c;

  assign adv          = !post_valid[6] || !result_stall;
  assign pop          = adv && !q_status.empty;
  assign result_valid = post_valid[6];

  always_comb begin
    x_c   = $signed({head.fine_temperature[31], head.fine_temperature}) - $signed(FINE_OFFSET);
    pw_c  = PRESS_FULL - {1'b0, head.raw_pressure};
    sq_c  = x0 * x0;
    t13_c = 64'($signed(pe) >>> 13);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_valid  <= '0;
      post_valid <= '0;
    end else if (adv) begin
      pre_valid  <= {pre_valid[6:0], pop};
      post_valid <= {post_valid[5:0], dv_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // s0: offset fine temperature, invert raw pressure
      tag0.temperature_centi <= head.temperature_centi;
      tag0.fine_temperature  <= head.fine_temperature;
      tag0.no_divisor        <= 1'b0;
      x0                     <= x_c;
      pw0                    <= pw_c;
      // s1: square and P5 term
      tag1  <= tag0;
      x1    <= x0;
      pw1   <= pw0;
      sq1   <= sq_c[63:0];
      xp5_1 <= x0 * $signed(cal.p5);
      // s2: P6 and P2 terms
      tag2   <= tag1;
      pw2    <= pw1;
      sq2    <= sq1;
      xp5_2  <= xp5_1;
      sqp6_2 <= mul64x17(sq1, {cal.p6[15], cal.p6});
      xp2_2  <= x1 * $signed(cal.p2);
      // s3: P3 term, first pressure offset sum
      tag3   <= tag2;
      pw3    <= pw2;
      xp2_3  <= xp2_2;
      sqp3_3 <= mul64x17(sq2, {cal.p3[15], cal.p3});
      v2_3   <= sqp6_2 + ({{15{xp5_2[48]}}, xp5_2} << 17) + ({{48{cal.p4[15]}}, cal.p4} << 35);
      // s4: sensitivity sum and numerator before scaling
      tag4      <= tag3;
      v1a_4     <= 64'($signed(sqp3_3) >>> 8) + ({{15{xp2_3[48]}}, xp2_3} << 12)
                   + (64'd1 << 47);
      num_pre_4 <= ({43'd0, pw3} << 31) - v2_3;
      // s5: P1 scaling
      tag5      <= tag4;
      num_pre_5 <= num_pre_4;
      v1b_5     <= mul64x17(v1a_4, {1'b0, cal.p1});
      // s6: divisor and scaled numerator
      tag6.temperature_centi <= tag5.temperature_centi;
      tag6.fine_temperature  <= tag5.fine_temperature;
      tag6.no_divisor        <= (v1b_5[63:33] == '0);
      d_6                    <= $signed(v1b_5[63:33]);
      num_6                  <= mul64x17(num_pre_5, PRESS_SCALE);
      // s7: magnitudes and quotient sign
      tag7  <= tag6;
      neg_7 <= num_6[63] ^ d_6[30];
      ua_7  <= num_6[63] ? 64'd0 - num_6 : num_6;
      ub_7  <= d_6[30] ? 31'd0 - d_6 : d_6;
      // after divide: restore sign
      tage <= dv_tag;
      pe   <= dv_neg ? 64'd0 - dv_q : dv_q;
      // p1: shifted value and P8 term
      tagp1 <= tage;
      pp1   <= pe;
      t13_1 <= t13_c;
      p8p_1 <= mul64x17(pe, {cal.p8[15], cal.p8});
      // p2: square of shifted value, partial products
      tagp2 <= tagp1;
      pp2   <= pp1;
      p8p_2 <= p8p_1;
      lo2_2 <= t13_1[31:0] * t13_1[31:0];
      hl_2  <= t13_1[63:32] * t13_1[31:0];
      // p3: combine square
      tagp3  <= tagp2;
      pp3    <= pp2;
      p8p_3  <= p8p_2;
      sq13_3 <= lo2_2 + {hl_2[30:0], 33'd0};
      // p4: P9 term
      tagp4 <= tagp3;
      pp4   <= pp3;
      p8p_4 <= p8p_3;
      m9_4  <= mul64x17(sq13_3, {cal.p9[15], cal.p9});
      // p5: correction sum
      tagp5 <= tagp4;
      sum_5 <= pp4 + 64'($signed(m9_4) >>> 25) + 64'($signed(p8p_4) >>> 19);
      // p6: output register
      temperature_centi <= tagp5.temperature_centi;
      fine_temperature  <= tagp5.fine_temperature;
      pressure_valid    <= !tagp5.no_divisor;
      pressure_q24_8    <= tagp5.no_divisor ? 32'd0
                           : sum_5[39:8] + {{12{cal.p7[15]}}, cal.p7, 4'd0};
    end
  end

  bsc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (pre_valid[7]),
    .in_tag    (tag7),
    .in_neg    (neg_7),
    .dividend  (ua_7),
    .divisor   (ub_7),
    .out_valid (dv_valid),
    .out_tag   (dv_tag),
    .out_neg   (dv_neg),
    .quotient  (dv_q)
  );

endmodule

`default_nettype wire

// ----- rtl/core/barometric_sensor_compensation.sv -----
// Top level of the barometric compensation block: register port and wiring.
// Depends on bsc_pkg, bsc_front, bsc_queue, bsc_back (and bsc_div below it).
// Each request carries one raw temperature and one raw pressure reading and
// yields one result: temperature in 0.01 degC, fine temperature, pressure in
// Q24.8 pascals and a flag that is low when the pressure divisor was zero
// (pressure then reads 0). One request is taken every cycle while raw_stall is
// low; the pressure path runs through the 64-stage pipelined divider plus
// the multiply stages around it. A front end works out temperature and feeds
// a small queue; the pressure back end drains it, so a stalled output holds
// the back end while the front keeps filling the queue. Calibration sits in
// four registers at byte addresses 0, 8, 16 and 24 (64-bit data) and must be
// written only while no request is in flight.
`default_nettype none

module barometric_sensor_compensation import bsc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [63:0]       pwdata,
  output logic [63:0]            prdata,
  output logic                   pready,
  // requests
  input  wire logic              raw_valid,
  output logic                   raw_stall,
  input  wire logic [19:0]       raw_temperature,
  input  wire logic [19:0]       raw_pressure,
  // results
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic signed [31:0]     temperature_centi,
  output logic signed [31:0]     fine_temperature,
  output logic [31:0]            pressure_q24_8,
  output logic                   pressure_valid
);

  logic [47:0] temp_calibration;
  logic [63:0] press_calibration_low;
  logic [63:0] press_calibration_high;
  logic [15:0] press_calibration_last;

  reg_idx_t      reg_sel;
  logic          wr_en;
  cal_t          cal;
  logic          push, pop;
  queue_item_t   push_item, head;
  queue_status_t q_status;
  logic [31:0]   temp_out, fine_out;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[4:3]);
  assign wr_en   = psel && penable && pwrite && pready;

  // calibration registers, reset to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calibration       <= '0;
      press_calibration_low  <= '0;
      press_calibration_high <= '0;
      press_calibration_last <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_TEMP_CAL:   temp_calibration       <= pwdata[47:0];
        REG_PRESS_LOW:  press_calibration_low  <= pwdata;
        REG_PRESS_HIGH: press_calibration_high <= pwdata;
        REG_PRESS_LAST: press_calibration_last <= pwdata[15:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TEMP_CAL:   prdata = {16'd0, temp_calibration};
      REG_PRESS_LOW:  prdata = press_calibration_low;
      REG_PRESS_HIGH: prdata = press_calibration_high;
      REG_PRESS_LAST: prdata = {48'd0, press_calibration_last};
      default:        prdata = '0;
    endcase
  end

  // unpack the twelve calibration words
  assign cal.t1 = temp_calibration[15:0];
  assign cal.t2 = temp_calibration[31:16];
  assign cal.t3 = temp_calibration[47:32];
  assign cal.p1 = press_calibration_low[15:0];
  assign cal.p2 = press_calibration_low[31:16];
  assign cal.p3 = press_calibration_low[47:32];
  assign cal.p4 = press_calibration_low[63:48];
  assign cal.p5 = press_calibration_high[15:0];
  assign cal.p6 = press_calibration_high[31:16];
  assign cal.p7 = press_calibration_high[47:32];
  assign cal.p8 = press_calibration_high[63:48];
  assign cal.p9 = press_calibration_last;

  bsc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cal             (cal),
    .raw_valid       (raw_valid),
    .raw_stall       (raw_stall),
    .raw_temperature (raw_temperature),
    .raw_pressure    (raw_pressure),
    .q_status        (q_status),
    .push            (push),
    .push_item       (push_item)
  );

  bsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  bsc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cal               (cal),
    .q_status          (q_status),
    .head              (head),
    .pop               (pop),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .temperature_centi (temp_out),
    .fine_temperature  (fine_out),
    .pressure_q24_8    (pressure_q24_8),
    .pressure_valid    (pressure_valid)
  );

  assign temperature_centi = $signed(temp_out);
  assign fine_temperature  = $signed(fine_out);

endmodule

`default_nettype wire

// ----- rtl/core/bsc_checker.sv -----
// Port-level checks for the barometric compensation top level, bound in below.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bsc_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               result_valid,
  input wire logic               result_stall,
  input wire logic signed [31:0] temperature_centi,
  input wire logic signed [31:0] fine_temperature,
  input wire logic [31:0]        pressure_q24_8,
  input wire logic               pressure_valid
);

  logic signed [31:0] f5;
  logic signed [31:0] temp_expect;

  assign f5          = (fine_temperature <<< 2) + fine_temperature + 32'sd128;
  assign temp_expect = f5 >>> 8;

  `BSC_ASSERT(a_hold_valid, result_valid && result_stall |=> result_valid, "result dropped under stall")
  `BSC_ASSERT(a_bad_press_zero, result_valid && !pressure_valid |-> pressure_q24_8 == 32'd0, "pressure not zero on bad divisor")
  `BSC_ASSERT(a_temp_matches_fine, result_valid |-> temperature_centi == temp_expect, "temperature out of step with fine value")
  `BSC_ASSERT_RST(a_reset_empty, rst |=> !result_valid, "result after reset")

endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (.*);

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking bench for barometric_sensor_compensation: drives raw requests,
// predicts each result from its own copy of the calibration, checks all fields.
// Depends on bsc_pkg and the barometric_sensor_compensation RTL.
`timescale 1ns / 1ps

module tb_top;
  import bsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 120;

  typedef struct {
    logic [19:0] raw_t;
    logic [19:0] raw_p;
  } raw_req_t;

  typedef struct {
    logic signed [31:0] temp;
    logic signed [31:0] fine;
    logic [31:0]        press;
    logic               pvalid;
  } comp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // register port
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [63:0]       pwdata  = '0;
  logic [63:0]       prdata;
  logic              pready;

  // request side
  logic        raw_valid       = 1'b0;
  logic        raw_stall;
  logic [19:0] raw_temperature = '0;
  logic [19:0] raw_pressure    = '0;

  // result side
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic signed [31:0] temperature_centi;
  logic signed [31:0] fine_temperature;
  logic [31:0]        pressure_q24_8;
  logic               pressure_valid;

  barometric_sensor_compensation u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .raw_valid(raw_valid), .raw_stall(raw_stall),
    .raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
    .result_valid(result_valid), .result_stall(result_stall),
    .temperature_centi(temperature_centi), .fine_temperature(fine_temperature),
    .pressure_q24_8(pressure_q24_8), .pressure_valid(pressure_valid)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Bench copy of the calibration registers (reset to zero like the block)
  logic [47:0] temp_cal   = '0;
  logic [63:0] press_low  = '0;
  logic [63:0] press_high = '0;
  logic [15:0] press_last = '0;

  raw_req_t raw_q[$];        // requests waiting to be driven
  comp_t    compensated_q[$]; // predicted results, oldest first
  int       errors = 0;
  int       req_count = 0;
  int       res_count = 0;
  int       invalid_count = 0;
  int       idle_cycles = 0;

  // Signed 64-bit divide, truncating; most negative / -1 wraps.
  function automatic logic signed [63:0] div_trunc(logic signed [63:0] n,
                                                   logic signed [63:0] d);
    logic [63:0] un, ud, q;
    un = n[63] ? -n : n;
    ud = d[63] ? -d : d;
    q  = un / ud;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic comp_t compensate(logic [19:0] rt, logic [19:0] rp);
    logic signed [31:0] t1, t2, t3, a, b, x, tv1, tv2, fine;
    logic signed [63:0] c1, c2, c3, c4, c5, c6, c7, c8, c9;
    logic signed [63:0] v1, v2, p, q13;
    comp_t r;
    t1 = {16'd0, temp_cal[15:0]};
    t2 = $signed(temp_cal[31:16]);
    t3 = $signed(temp_cal[47:32]);
    // temperature: 32-bit wrap, arithmetic shifts
    a    = {15'd0, rt[19:3]} - (t1 <<< 1);
    tv1  = (a * t2) >>> 11;
    b    = {16'd0, rt[19:4]} - t1;
    x    = b * b;
    x    = x >>> 12;
    tv2  = (x * t3) >>> 14;
    fine = tv1 + tv2;
    x    = fine * 32'sd5 + 32'sd128;
    r.temp = x >>> 8;
    r.fine = fine;
    // pressure: 64-bit wrap
    c1 = {48'd0, press_low[15:0]};
    c2 = $signed(press_low[31:16]);
    c3 = $signed(press_low[47:32]);
    c4 = $signed(press_low[63:48]);
    c5 = $signed(press_high[15:0]);
    c6 = $signed(press_high[31:16]);
    c7 = $signed(press_high[47:32]);
    c8 = $signed(press_high[63:48]);
    c9 = $signed(press_last);
    v1 = fine;
    v1 = v1 - 64'sd128000;
    v2 = v1 * v1 * c6;
    v2 = v2 + ((v1 * c5) <<< 17);
    v2 = v2 + (c4 <<< 35);
    v1 = ((v1 * v1 * c3) >>> 8) + ((v1 * c2) <<< 12);
    v1 = ((64'sd1 <<< 47) + v1) * c1;
    v1 = v1 >>> 33;
    if (v1 == 0) begin
      // zero divisor: pressure forced to 0, flag low
      r.press  = '0;
      r.pvalid = 1'b0;
    end else begin
      p   = 64'sd1048576 - $signed({44'd0, rp});
      p   = div_trunc(((p <<< 31) - v2) * 64'sd3125, v1);
      q13 = p >>> 13;
      v1  = (c9 * q13 * q13) >>> 25;
      v2  = (c8 * p) >>> 19;
      p   = ((p + v1 + v2) >>> 8) + (c7 <<< 4);
      r.press  = p[31:0];
      r.pvalid = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- driver
  int  src_gap = 0;
  bit  src_burst = 0;
  always @(posedge clk) begin
    raw_req_t nxt;
    int       g;
    if (rst) begin
      raw_valid <= 1'b0;
    end else if (raw_valid && !raw_stall) begin
      compensated_q.push_back(compensate(raw_temperature, raw_pressure));
      req_count++;
      if ($urandom_range(0, 63) == 0) src_burst = ~src_burst;
      g = src_burst ? 0 : $urandom_range(0, 12);
      if (g == 0 && raw_q.size() != 0) begin
        // back-to-back: valid stays high, new payload
        nxt = raw_q.pop_front();
        raw_temperature <= nxt.raw_t;
        raw_pressure    <= nxt.raw_p;
      end else begin
        raw_valid <= 1'b0;
        src_gap = g;
      end
    end else if (!raw_valid) begin
      if (src_gap > 0) begin
        src_gap--;
      end else if (raw_q.size() != 0) begin
        nxt = raw_q.pop_front();
        raw_temperature <= nxt.raw_t;
        raw_pressure    <= nxt.raw_p;
        raw_valid       <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------- monitor
  int  sink_gap = 0;
  bit  sink_burst = 0;
  always @(posedge clk) begin
    comp_t e;
    int    g;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      g = (sink_gap > 0) ? sink_gap - 1 : 0;
      if (result_valid && !result_stall) begin
        res_count++;
        if (compensated_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result temp=%0d fine=%0d press=%h valid=%b", $time,
                   temperature_centi, fine_temperature, pressure_q24_8, pressure_valid);
        end else begin
          e = compensated_q.pop_front();
          if (!e.pvalid) invalid_count++;
          if (temperature_centi !== e.temp) begin
            errors++;
            $display("%0t: temperature_centi expected %0d got %0d", $time,
                     e.temp, temperature_centi);
          end
          if (fine_temperature !== e.fine) begin
            errors++;
            $display("%0t: fine_temperature expected %0d got %0d", $time,
                     e.fine, fine_temperature);
          end
          if (pressure_q24_8 !== e.press) begin
            errors++;
            $display("%0t: pressure_q24_8 expected %h got %h", $time,
                     e.press, pressure_q24_8);
          end
          if (pressure_valid !== e.pvalid) begin
            errors++;
            $display("%0t: pressure_valid expected %b got %b", $time,
                     e.pvalid, pressure_valid);
          end
        end
        if ($urandom_range(0, 63) == 0) sink_burst = ~sink_burst;
        g = sink_burst ? 0 : $urandom_range(0, 12);
      end
      sink_gap = g;
      result_stall <= (g > 0);
    end
  end

  // -------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if ((raw_valid && !raw_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               compensated_q.size());
      $display("FAIL barometric_sensor_compensation");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ------------------------------------------------------------- stimulus
  task automatic write_reg(reg_idx_t idx, logic [63:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TEMP_CAL:   temp_cal   = data[47:0];
      REG_PRESS_LOW:  press_low  = data;
      REG_PRESS_HIGH: press_high = data;
      REG_PRESS_LAST: press_last = data[15:0];
      default: ;
    endcase
  endtask

  // sender holds off until every predicted result has come back
  task automatic drain();
    while (raw_q.size() != 0 || raw_valid || compensated_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_cal(logic [63:0] tc, logic [63:0] pl, logic [63:0] ph,
                         logic [63:0] last);
    drain();
    write_reg(REG_TEMP_CAL, tc);
    write_reg(REG_PRESS_LOW, pl);
    write_reg(REG_PRESS_HIGH, ph);
    write_reg(REG_PRESS_LAST, last);
  endtask

  task automatic push_req(logic [19:0] rt, logic [19:0] rp);
    raw_req_t r;
    r.raw_t = rt;
    r.raw_p = rp;
    raw_q.push_back(r);
  endtask

  // Typical factory calibration
  localparam logic [63:0] TYP_T  = {16'h0, 16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TYP_PL = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
  localparam logic [63:0] TYP_PH = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
  localparam logic [63:0] TYP_P9 = 64'd6000;

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // typical words with small random offsets in each 16-bit slice
  function automatic logic [63:0] jitter(logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 4; i++)
      r[16*i +: 16] = v[16*i +: 16] + 16'($urandom_range(0, 511)) - 16'd256;
    return r;
  endfunction

  initial begin
    logic [63:0] pl;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset calibration: divisor is zero, temperature path still runs
    push_req(20'h00000, 20'h00000);
    push_req(20'hFFFFF, 20'hFFFFF);
    push_req(20'd519888, 20'd415148);

    set_cal(TYP_T, TYP_PL, TYP_PH, TYP_P9);
    push_req(20'h00000, 20'h00000);
    push_req(20'hFFFFF, 20'hFFFFF);
    push_req(20'h00000, 20'hFFFFF);
    push_req(20'hFFFFF, 20'h00000);
    push_req(20'd519888, 20'd415148);
    push_req(20'hAAAAA, 20'h55555);
    push_req(20'h55555, 20'hAAAAA);

    // P1 = 0: zero divisor with otherwise sane calibration
    set_cal(TYP_T, {TYP_PL[63:16], 16'd0}, TYP_PH, TYP_P9);
    push_req(20'd519888, 20'd415148);
    push_req(20'hFFFFF, 20'h00000);

    // all ones, most negative and most positive slices
    set_cal({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
    push_req(20'h00000, 20'hFFFFF);
    push_req(20'hFFFFF, 20'h00000);
    push_req(20'd519888, 20'd415148);
    set_cal({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 64'h8000);
    push_req(20'h00000, 20'h00000);
    push_req(20'hFFFFF, 20'hFFFFF);
    push_req(20'd519888, 20'd415148);
    set_cal({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, 64'h7FFF);
    push_req(20'h00000, 20'h00000);
    push_req(20'hFFFFF, 20'hFFFFF);
    push_req(20'd519888, 20'd415148);

    // Random phases: alternate near-typical and fully random calibration
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 2 == 0) begin
        set_cal(jitter(TYP_T), jitter(TYP_PL), jitter(TYP_PH), jitter(TYP_P9));
      end else begin
        pl = rnd64();
        if (ph == 5) pl[15:0] = '0;  // another zero-divisor stretch
        set_cal(rnd64(), pl, rnd64(), rnd64());
      end
      for (int i = 0; i < 275; i++) begin
        if ($urandom_range(0, 9) < 6)
          push_req(20'($urandom_range(400000, 600000)), 20'($urandom_range(200000, 700000)));
        else
          push_req(20'($urandom), 20'($urandom));
      end
    end

    drain();
    $display("Ran %0d requests over 12 calibration settings, %0d results checked",
             req_count, res_count);
    $display("%0d results had a zero pressure divisor, %0d mismatches",
             invalid_count, errors);
    if (errors == 0 && compensated_q.size() == 0) begin
      $display("PASS barometric_sensor_compensation");
    end else begin
      $display("FAIL barometric_sensor_compensation");
    end
    $finish;
  end

endmodule
